>>> design/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(CAPACITY);

  localparam int BS_W    = 17;
  localparam int INIT_W  = 11;
  localparam int OFS_W   = 26;
  localparam int FREE_W  = 11;
  localparam int CTR_W   = 32;
  localparam logic [FREE_W-1:0] FREE_MAX = '1;
  localparam logic [BS_W-1:0]   MIN_BLOCK = BS_W'(8);

  localparam logic [BS_W-1:0]   BS_RESET   = BS_W'(64);
  localparam logic [INIT_W-1:0] INIT_RESET = INIT_W'(64);

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_BLOCKS = 1'b1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROW,
    S_FETCH,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted;
    status_t           status;
    logic [FREE_W-1:0] free_cnt;
    logic [CNT_W-1:0]  total_cnt;
    logic [CTR_W-1:0]  alloc_cnt;
    logic [CTR_W-1:0]  release_cnt;
  } res_t;

endpackage

>>> design/fbpa_ram.sv
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fbpa_core.sv
`timescale 1ns / 1ps

module fbpa_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [fbpa_pkg::IDX_W-1:0]  idx,
  input  logic                        handle_valid,
  input  logic [fbpa_pkg::INIT_W-1:0] init_blocks,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fbpa_pkg::res_t              res
);

  import fbpa_pkg::*;

  fsm_t state_r, state_nxt;

  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [CTR_W-1:0]  alloc_r, alloc_nxt;
  logic [CTR_W-1:0]  rel_r, rel_nxt;

  logic              op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  granted_r, granted_nxt;
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  grow_k_r, grow_k_nxt;
  logic [CNT_W-1:0]  grow_n_r, grow_n_nxt;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [CNT_W-1:0]  mem_wdata, mem_rdata;

  logic              accept, commit, head_empty, rel_ok;
  logic [CNT_W-1:0]  n_raw, room, grow_n;
  logic [CNT_W-1:0]  grow_idx;
  logic              grow_last;
  logic [FREE_W:0]   free_grow;
  logic [FREE_W-1:0] free_upd;
  logic [CTR_W-1:0]  alloc_upd, rel_upd;

  fbpa_ram #(
    .WIDTH(CNT_W),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign accept     = in_valid && in_ready;
  assign commit     = res_valid && res_ready;
  assign head_empty = (head_r >= NULL_LINK);
  assign rel_ok     = handle_valid && ({1'b0, idx} < NULL_LINK);

  // growth size: first time from config, then doubling, clipped to what is left
  always_comb begin
    if (total_r == '0) begin
      n_raw = (init_blocks == '0) ? CNT_W'(1) : CNT_W'(init_blocks);
    end else begin
      n_raw = total_r;
    end
    room   = NULL_LINK - total_r;
    grow_n = (n_raw > room) ? room : n_raw;
  end

  assign grow_idx  = total_r + grow_k_r;
  assign grow_last = (grow_k_r == grow_n_r - CNT_W'(1));
  assign free_grow = {1'b0, free_r} + (FREE_W + 1)'(grow_n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_ALLOC && head_empty && grow_n != '0) begin
            state_nxt = S_GROW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_GROW: begin
        if (grow_last) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: handshakes and link memory port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = grow_idx[IDX_W-1:0];
    mem_wdata = NULL_LINK;
    mem_re    = 1'b0;
    mem_raddr = head_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_valid && op == OP_ALLOC && !head_empty;
      end
      S_GROW: begin
        mem_we    = 1'b1;
        mem_wdata = (grow_k_r == '0) ? NULL_LINK : grow_idx - CNT_W'(1);
      end
      S_FETCH: mem_re = 1'b1;
      S_DONE: begin
        res_valid = 1'b1;
        if (op_r == OP_RELEASE && status_r == ST_DONE) begin
          mem_we    = res_ready;
          mem_waddr = idx_r;
          mem_wdata = head_r;
        end
      end
      default: ;
    endcase
  end

  // committed values, shown in the result beat
  always_comb begin
    free_upd  = free_r;
    alloc_upd = alloc_r;
    rel_upd   = rel_r;
    if (status_r == ST_DONE) begin
      if (op_r == OP_ALLOC) begin
        free_upd  = (free_r == '0) ? free_r : free_r - FREE_W'(1);
        alloc_upd = alloc_r + CTR_W'(1);
      end else begin
        free_upd = (free_r == FREE_MAX) ? free_r : free_r + FREE_W'(1);
        rel_upd  = rel_r + CTR_W'(1);
      end
    end
  end

  always_comb begin
    res.granted     = (op_r == OP_ALLOC && status_r == ST_DONE) ? granted_r : '0;
    res.status      = status_r;
    res.free_cnt    = free_upd;
    res.total_cnt   = total_r;
    res.alloc_cnt   = alloc_upd;
    res.release_cnt = rel_upd;
  end

  // datapath registers
  always_comb begin
    head_nxt    = head_r;
    total_nxt   = total_r;
    free_nxt    = free_r;
    alloc_nxt   = alloc_r;
    rel_nxt     = rel_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    granted_nxt = granted_r;
    status_nxt  = status_r;
    grow_k_nxt  = grow_k_r;
    grow_n_nxt  = grow_n_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = op;
          idx_nxt     = idx;
          granted_nxt = head_r[IDX_W-1:0];
          grow_k_nxt  = '0;
          grow_n_nxt  = grow_n;
          if (op == OP_ALLOC) begin
            status_nxt = (head_empty && grow_n == '0) ? ST_EXHAUSTED : ST_DONE;
          end else begin
            status_nxt = rel_ok ? ST_DONE : ST_IGNORED;
          end
        end
      end
      S_GROW: begin
        grow_k_nxt = grow_k_r + CNT_W'(1);
        if (grow_last) begin
          head_nxt  = grow_idx;
          total_nxt = total_r + grow_n_r;
          free_nxt  = (free_grow > (FREE_W + 1)'(FREE_MAX)) ? FREE_MAX
                                                            : free_grow[FREE_W-1:0];
        end
      end
      S_FETCH: granted_nxt = head_r[IDX_W-1:0];
      S_DONE: begin
        if (commit) begin
          free_nxt  = free_upd;
          alloc_nxt = alloc_upd;
          rel_nxt   = rel_upd;
          if (status_r == ST_DONE) begin
            head_nxt = (op_r == OP_ALLOC) ? mem_rdata : {1'b0, idx_r};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= NULL_LINK;
      total_r  <= '0;
      free_r   <= '0;
      alloc_r  <= '0;
      rel_r    <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      free_r   <= free_nxt;
      alloc_r  <= alloc_nxt;
      rel_r    <= rel_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    granted_r <= granted_nxt;
    grow_k_r  <= grow_k_nxt;
    grow_n_r  <= grow_n_nxt;
  end

endmodule

>>> design/fbpa_obuf.sv
`timescale 1ns / 1ps

module fbpa_obuf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 res_valid,
  output logic                                 res_ready,
  input  fbpa_pkg::res_t                       res,
  input  logic [fbpa_pkg::BS_W-1:0]            blk_bytes,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [fbpa_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  import fbpa_pkg::*;

  localparam int PROD_W = IDX_W + BS_W;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic [OUT_TUSER_W-1:0] user_r, user_nxt;
  logic [BS_W-1:0]        bs_eff;
  logic [PROD_W-1:0]      prod;
  logic                   load;

  assign res_ready = !valid_r || out_tready;
  assign load      = res_valid && res_ready;

  assign bs_eff = (blk_bytes < MIN_BLOCK) ? MIN_BLOCK : blk_bytes;
  assign prod   = PROD_W'(res.granted) * PROD_W'(bs_eff);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = OUT_TDATA_W'({res.release_cnt, res.alloc_cnt, res.total_cnt,
                                res.free_cnt, prod[OFS_W-1:0], res.granted});
      user_nxt  = OUT_TUSER_W'(res.status);
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

>>> design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Each input beat allocates (tuser[0] = 0) or
// releases (tuser[0] = 1) a block; one result beat follows per input beat. Free
// blocks form a LIFO list whose links live in a single-port-write, registered-
// read link RAM of CAPACITY entries. When an allocate finds the list non-empty,
// the accept cycle issues the link RAM read of the list head; in the result
// state, once the output register can take the result, the pop or push commits
// and the result is handed to it. When an allocate finds the list empty, the pool
// grows (first by initial_blocks, then doubling, up to CAPACITY) and the new links
// are written one per cycle before the new head is read. At capacity, status
// reports exhaustion. No double-free check is made. The link RAM needs no clearing.

module fixed_block_pool_allocator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [9:0] block_index, rest zero
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: [0] op, [1] handle_valid
  input  logic [fbpa_pkg::IN_TUSER_W-1:0]       in_tuser,
  // out_tdata: [9:0] granted_index, [35:10] byte_offset, [46:36] free_count,
  //            [57:47] total_count, [89:58] alloc_total, [121:90] release_total
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: [1:0] status
  output logic [fbpa_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                  cfg_we,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [fbpa_pkg::BS_W-1:0]             cfg_wdata
);

  import fbpa_pkg::*;

  logic [BS_W-1:0]   blk_bytes_r;
  logic [INIT_W-1:0] init_blocks_r;
  logic              res_valid, res_ready;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_bytes_r   <= BS_RESET;
      init_blocks_r <= INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BLOCK_SIZE:  blk_bytes_r   <= cfg_wdata;
        REG_INIT_BLOCKS: init_blocks_r <= cfg_wdata[INIT_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser[0]),
    .idx         (in_tdata[IDX_W-1:0]),
    .handle_valid(in_tuser[1]),
    .init_blocks (init_blocks_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fbpa_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .blk_bytes (blk_bytes_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  localparam int TOT_LSB = IDX_W + OFS_W + FREE_W;

  // one item in flight: the cycle after an accept never accepts
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TOT_LSB +: CNT_W] <= NULL_LINK)
    else $error("total count beyond capacity");

  a_exhaust_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OUT_TUSER_W'(ST_EXHAUSTED)
      |-> out_tdata[TOT_LSB +: CNT_W] == NULL_LINK)
    else $error("exhaustion reported below capacity");

endmodule

>>> tb/fbpa_checker.sv
`timescale 1ns / 1ps

module fbpa_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [fbpa_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fbpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [fbpa_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             cfg_we,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fbpa_pkg::BS_W-1:0]        cfg_wdata,
  output int                               errors,
  output int                               pending
);

  import fbpa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  granted;
    logic [OFS_W-1:0]  offset;
    status_t           status;
    logic [FREE_W-1:0] free_cnt;
    logic [CNT_W-1:0]  total_cnt;
    logic [CTR_W-1:0]  alloc_cnt;
    logic [CTR_W-1:0]  release_cnt;
  } pool_reply_t;

  // shadow of the pool
  logic [CNT_W-1:0]  link_ram [CAPACITY];
  logic [CNT_W-1:0]  head;
  int unsigned       pool_total;
  int unsigned       pool_free;
  logic [CTR_W-1:0]  allocs;
  logic [CTR_W-1:0]  releases;
  logic [BS_W-1:0]   bsize;
  logic [INIT_W-1:0] first_grow;

  pool_reply_t pool_replies[$];
  int          fails = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic pool_reply_t pool_step(logic op, logic [IDX_W-1:0] idx, logic hv);
    pool_reply_t           r;
    int unsigned           n;
    int unsigned           k;
    logic [BS_W-1:0]       bs;
    logic [IDX_W+BS_W-1:0] prod;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_ALLOC) begin
      if (head == NULL_LINK) begin
        n = (pool_total == 0) ? first_grow : pool_total;
        if (n == 0) n = 1;
        if (n > CAPACITY - pool_total) n = CAPACITY - pool_total;
        // ascending links leave the highest new index on top
        for (k = 0; k < n; k++) begin
          link_ram[pool_total + k] = head;
          head = CNT_W'(pool_total + k);
        end
        pool_total += n;
        pool_free = (pool_free + n > FREE_MAX) ? FREE_MAX : pool_free + n;
      end
      if (head == NULL_LINK) begin
        r.status = ST_EXHAUSTED;
      end else begin
        bs = (bsize < MIN_BLOCK) ? MIN_BLOCK : bsize;
        r.granted = head[IDX_W-1:0];
        prod = r.granted * bs;
        r.offset = prod[OFS_W-1:0];
        head = link_ram[r.granted];
        if (pool_free > 0) pool_free--;
        allocs++;
      end
    end else if (!hv) begin
      r.status = ST_IGNORED;
    end else begin
      link_ram[idx] = head;
      head = {1'b0, idx};
      if (pool_free < FREE_MAX) pool_free++;
      releases++;
    end
    r.free_cnt    = FREE_W'(pool_free);
    r.total_cnt   = CNT_W'(pool_total);
    r.alloc_cnt   = allocs;
    r.release_cnt = releases;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [CTR_W-1:0] want,
                                        logic [CTR_W-1:0] got);
    if (want !== got) begin
      if (fails < 10) $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name,
                               want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst_n) begin
      head       = NULL_LINK;
      pool_total = 0;
      pool_free  = 0;
      allocs     = '0;
      releases   = '0;
      bsize      = BS_RESET;
      first_grow = INIT_RESET;
      pool_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BLOCK_SIZE:  bsize = cfg_wdata;
          REG_INIT_BLOCKS: first_grow = cfg_wdata[INIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pool_replies.insert(pool_replies.size(),
                            pool_step(in_tuser[0], in_tdata[IDX_W-1:0], in_tuser[1]));
      if (out_tvalid && out_tready) begin
        if (pool_replies.size() == 0) begin
          if (fails < 10) $display("%0t result beat with nothing outstanding", $realtime);
          fails++;
        end else begin
          want = pool_replies.pop_front();
          compare_field("granted_index", CTR_W'(want.granted),     CTR_W'(out_tdata[9:0]));
          compare_field("byte_offset",   CTR_W'(want.offset),      CTR_W'(out_tdata[35:10]));
          compare_field("status",        CTR_W'(want.status),      CTR_W'(out_tuser[1:0]));
          compare_field("free_count",    CTR_W'(want.free_cnt),    CTR_W'(out_tdata[46:36]));
          compare_field("total_count",   CTR_W'(want.total_cnt),   CTR_W'(out_tdata[57:47]));
          compare_field("alloc_total",   want.alloc_cnt,           out_tdata[89:58]);
          compare_field("release_total", want.release_cnt,         out_tdata[121:90]);
        end
      end
    end
    errors  <= fails;
    pending <= pool_replies.size();
  end

endmodule

>>> tb/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [BS_W-1:0]        cfg_wdata = '0;
  int                     errors;
  int                     pending;

  int               idle_pct = 0;
  int               stall_pct = 0;
  bit               press_req = 1'b0;
  bit               press_done = 1'b0;
  logic [IDX_W-1:0] held[$];
  logic [CTR_W-1:0] seen_allocs = '0;

  fixed_block_pool_allocator dut (.*);
  fbpa_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off to back up the pool
  initial begin
    forever begin
      @(posedge clk);
      if (press_req && !press_done) begin
        press_done = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // remember granted blocks so releases can hand them back
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[89:58] != seen_allocs) begin
      seen_allocs = out_tdata[89:58];
      if (held.size() < 2048) held.insert(held.size(), out_tdata[9:0]);
    end
  end

  task automatic send_beat(logic op, logic [IDX_W-1:0] idx, logic hv);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(idx);
    in_tuser  <= {hv, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_beat();
    int               pick;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(99) < 55) begin
      send_beat(OP_ALLOC, IDX_W'($urandom), 1'($urandom));
    end else if (held.size() > 0 && $urandom_range(99) < 75) begin
      pick = $urandom_range(held.size() - 1);
      idx = held[pick];
      held.delete(pick);
      send_beat(OP_RELEASE, idx, 1'b1);
    end else begin
      send_beat(OP_RELEASE, IDX_W'($urandom), $urandom_range(99) < 70);
    end
  endtask

  task automatic run_phase(int sp, int rp, int count);
    idle_pct  = sp;
    stall_pct = rp;
    repeat (count) random_beat();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(logic [BS_W-1:0] bs, logic [INIT_W-1:0] init);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BLOCK_SIZE;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_addr  <= REG_INIT_BLOCKS;
    cfg_wdata <= BS_W'(init);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // block size below the minimum; first growth of three
    write_cfg(BS_W'(3), INIT_W'(3));
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_ALLOC, '1, 1'b1);           // empty list, pool doubles
    send_beat(OP_RELEASE, '1, 1'b0);         // null release
    send_beat(OP_RELEASE, '1, 1'b1);         // never granted, still pushed
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_RELEASE, '0, 1'b1);
    send_beat(OP_RELEASE, '0, 1'b1);         // double release
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_ALLOC, '0, 1'b0);
    send_beat(OP_RELEASE, IDX_W'(10'h2AA), 1'b0);
    send_beat(OP_RELEASE, IDX_W'(10'h155), 1'b1);
    repeat (4) send_beat(OP_ALLOC, '0, 1'b1);
    settle();

    write_cfg(BS_W'(65536), INIT_W'(1024));
    run_phase(0, 0, 75);
    settle();

    write_cfg(BS_W'(8), INIT_W'(1));
    run_phase(51, 0, 75);
    settle();

    // offset truncation with the widest block size
    write_cfg('1, '1);
    press_req = 1'b1;
    run_phase(0, 51, 75);
    settle();

    write_cfg(BS_W'($urandom_range(8, 65536)), INIT_W'($urandom_range(1, 1024)));
    run_phase(34, 34, 75);
    settle();

    run_phase(34, 34, 75);
    settle();
    repeat (20) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
